// ===== hdl/wfr_pkg.sv =====
package wfr_pkg;

  localparam int PhaseW = 3;
  localparam logic [PhaseW-1:0] PH_HDR0   = 3'd0;
  localparam logic [PhaseW-1:0] PH_HDR1   = 3'd1;
  localparam logic [PhaseW-1:0] PH_EXT    = 3'd2;
  localparam logic [PhaseW-1:0] PH_MASK   = 3'd3;
  localparam logic [PhaseW-1:0] PH_DATA   = 3'd4;
  localparam logic [PhaseW-1:0] PH_CLOSED = 3'd5;
  localparam logic [PhaseW-1:0] PH_STOP   = 3'd6;

  localparam logic [1:0] EV_DATA   = 2'd0;
  localparam logic [1:0] EV_CLOSED = 2'd1;
  localparam logic [1:0] EV_ERROR  = 2'd2;

  localparam logic [7:0] OP_BINARY = 8'h82;
  localparam logic [7:0] OP_CLOSE  = 8'h88;
  localparam logic [7:0] OP_CONT   = 8'h00;

  localparam logic [6:0] LEN_EXT16 = 7'h7e;
  localparam logic [6:0] LEN_EXT64 = 7'h7f;

  typedef struct packed {
    logic       valid;
    logic [1:0] kind;
    logic [7:0] data;
    logic       last;
  } result_t;

endpackage

// ===== hdl/wfr_parser.sv =====
module wfr_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  logic [7:0]         rx_byte,
  output wfr_pkg::result_t   result
);

  logic [2:0]  phase, phase_next;
  logic        is_close, is_close_next;
  logic        mask_present, mask_present_next;
  logic        ext_long, ext_long_next;
  logic [2:0]  hdr_count, hdr_count_next;
  logic [31:0] mask_key, mask_key_next;
  logic [63:0] bytes_left, bytes_left_next;
  logic [1:0]  key_position, key_position_next;

  logic        go_after, go_done;
  logic [2:0]  ext_last;
  logic [7:0]  key_byte;
  logic        data_end;

  assign ext_last = ext_long ? 3'd7 : 3'd1;
  assign key_byte = mask_present ? mask_key[{~key_position, 3'b000} +: 8] : 8'h00;
  assign data_end = (bytes_left == 64'd1);

  always_comb begin
    phase_next        = phase;
    is_close_next     = is_close;
    mask_present_next = mask_present;
    ext_long_next     = ext_long;
    hdr_count_next    = hdr_count;
    mask_key_next     = mask_key;
    bytes_left_next   = bytes_left;
    key_position_next = key_position;
    result            = '0;
    go_after          = 1'b0;
    go_done           = 1'b0;

    unique case (phase)
      wfr_pkg::PH_HDR0: begin
        if (rx_byte == wfr_pkg::OP_BINARY || rx_byte == wfr_pkg::OP_CLOSE ||
            rx_byte == wfr_pkg::OP_CONT) begin
          is_close_next = (rx_byte == wfr_pkg::OP_CLOSE);
          phase_next    = wfr_pkg::PH_HDR1;
        end else begin
          phase_next   = wfr_pkg::PH_STOP;
          result.valid = 1'b1;
          result.kind  = wfr_pkg::EV_ERROR;
        end
      end
      wfr_pkg::PH_HDR1: begin
        mask_present_next = rx_byte[7];
        hdr_count_next    = 3'd0;
        if (rx_byte[6:0] == wfr_pkg::LEN_EXT16 || rx_byte[6:0] == wfr_pkg::LEN_EXT64) begin
          ext_long_next   = (rx_byte[6:0] == wfr_pkg::LEN_EXT64);
          bytes_left_next = 64'd0;
          phase_next      = wfr_pkg::PH_EXT;
        end else begin
          bytes_left_next = {57'd0, rx_byte[6:0]};
          go_after        = 1'b1;
        end
      end
      wfr_pkg::PH_EXT: begin
        bytes_left_next = {bytes_left[55:0], rx_byte};
        if (hdr_count >= ext_last) go_after = 1'b1;
        else hdr_count_next = hdr_count + 3'd1;
      end
      wfr_pkg::PH_MASK: begin
        mask_key_next = {mask_key[23:0], rx_byte};
        if (hdr_count >= 3'd3) go_done = 1'b1;
        else hdr_count_next = hdr_count + 3'd1;
      end
      wfr_pkg::PH_DATA: begin
        key_position_next = key_position + 2'd1;
        bytes_left_next   = bytes_left - 64'd1;
        if (is_close) begin
          if (data_end) begin
            phase_next   = wfr_pkg::PH_CLOSED;
            result.valid = 1'b1;
            result.kind  = wfr_pkg::EV_CLOSED;
          end
        end else begin
          if (data_end) phase_next = wfr_pkg::PH_HDR0;
          result.valid = 1'b1;
          result.kind  = wfr_pkg::EV_DATA;
          result.data  = rx_byte ^ key_byte;
          result.last  = data_end;
        end
      end
      default: begin
        // closed, stopped and the unused code drop everything
      end
    endcase

    if (go_after) begin
      hdr_count_next = 3'd0;
      if (mask_present_next) phase_next = wfr_pkg::PH_MASK;
      else go_done = 1'b1;
    end

    if (go_done) begin
      key_position_next = 2'd0;
      hdr_count_next    = 3'd0;
      if (bytes_left_next != 64'd0) begin
        phase_next = wfr_pkg::PH_DATA;
      end else if (is_close) begin
        phase_next   = wfr_pkg::PH_CLOSED;
        result.valid = 1'b1;
        result.kind  = wfr_pkg::EV_CLOSED;
      end else begin
        phase_next = wfr_pkg::PH_HDR0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= wfr_pkg::PH_HDR0;
      is_close     <= 1'b0;
      mask_present <= 1'b0;
      ext_long     <= 1'b0;
      hdr_count    <= 3'd0;
      bytes_left   <= 64'd0;
      key_position <= 2'd0;
    end else if (step) begin
      phase        <= phase_next;
      is_close     <= is_close_next;
      mask_present <= mask_present_next;
      ext_long     <= ext_long_next;
      hdr_count    <= hdr_count_next;
      bytes_left   <= bytes_left_next;
      key_position <= key_position_next;
    end
  end

  // key is always fully loaded before a masked payload uses it
  always_ff @(posedge clk) begin
    if (step) mask_key <= mask_key_next;
  end

endmodule

// ===== hdl/websocket_frame_receiver.sv =====
// WebSocket frame receiver: takes one received byte per transaction and
// returns payload bytes unmasked, with frame_end on the last byte of each
// binary or continuation frame. First bytes other than final binary, final
// close and continuation give one protocol-error event and the block then
// drops every byte until reset; a close frame gives one closed event after
// its payload and later bytes are dropped. Empty data frames give nothing.
// Throughput is one byte per clock while the output is not stalled: a byte
// sits in the input register, the header/payload parser decides on it, and
// its result (if any) lands in the output register; a stalled output holds
// back at most one byte in the input register.
module websocket_frame_receiver (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] event_kind,
  output logic [7:0] payload_byte,
  output logic       frame_end
);

  logic             s1_valid;
  logic [7:0]       s1_byte;
  logic             advance;
  wfr_pkg::result_t result;

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else if (in_ready) s1_valid <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) s1_byte <= rx_byte;
  end

  wfr_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .rx_byte (s1_byte),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (advance) out_valid <= result.valid;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (advance && result.valid) begin
      event_kind   <= result.kind;
      payload_byte <= result.data;
      frame_end    <= result.last;
    end
  end

endmodule

// ===== hdl/wfr_checker.sv =====
module wfr_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] event_kind,
  input logic [7:0] payload_byte,
  input logic       frame_end
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(event_kind) &&
      $stable(payload_byte) && $stable(frame_end))
    else $error("output changed while stalled");

  a_event_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_kind != wfr_pkg::EV_DATA |-> payload_byte == 8'h00 && !frame_end)
    else $error("non-data event carries payload bits");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> event_kind == wfr_pkg::EV_DATA || event_kind == wfr_pkg::EV_CLOSED ||
      event_kind == wfr_pkg::EV_ERROR)
    else $error("bad event kind");

  a_terminal: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && event_kind != wfr_pkg::EV_DATA |=> !out_valid)
    else $error("output after close or error");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind websocket_frame_receiver wfr_checker u_wfr_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .event_kind   (event_kind),
  .payload_byte (payload_byte),
  .frame_end    (frame_end)
);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int StallLimit = 2000;
  localparam int DrainCycles = 20;

  typedef struct {
    logic [1:0] kind;
    logic [7:0] data;
    logic       last;
  } rx_event_t;

  typedef enum int {FORM_SHORT, FORM_16, FORM_64} len_form_t;
  typedef enum int {END_ERROR, END_CLOSE, END_HUGE} conn_end_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] rx_byte;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] event_kind;
  logic [7:0] payload_byte;
  logic       frame_end;

  // deframer state as seen from outside
  logic [wfr_pkg::PhaseW-1:0] rx_phase;
  logic [7:0]                 frame_op;
  logic                       frame_masked;
  logic [6:0]                 frame_len_code;
  logic [2:0]                 hdr_count;
  logic [31:0]                frame_key;
  logic [63:0]                payload_left;
  logic [1:0]                 key_pos;

  rx_event_t pending_events[$];
  int errors = 0;
  int bytes_sent = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  websocket_frame_receiver DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .rx_byte(rx_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .event_kind(event_kind),
    .payload_byte(payload_byte),
    .frame_end(frame_end)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic queue_event(input logic [1:0] kind, input logic [7:0] data,
                             input logic last);
    rx_event_t ev;
    ev.kind = kind;
    ev.data = data;
    ev.last = last;
    pending_events.push_back(ev);
  endtask

  task automatic finish_header();
    key_pos = 2'd0;
    hdr_count = 3'd0;
    if (payload_left != 64'd0) begin
      rx_phase = wfr_pkg::PH_DATA;
    end else if (frame_op == wfr_pkg::OP_CLOSE) begin
      rx_phase = wfr_pkg::PH_CLOSED;
      queue_event(wfr_pkg::EV_CLOSED, 8'h00, 1'b0);
    end else begin
      rx_phase = wfr_pkg::PH_HDR0;
    end
  endtask

  task automatic finish_length();
    hdr_count = 3'd0;
    if (frame_masked) rx_phase = wfr_pkg::PH_MASK;
    else finish_header();
  endtask

  task automatic deframe_byte(input logic [7:0] b);
    logic [7:0] k;
    logic       done;
    case (rx_phase)
      wfr_pkg::PH_HDR0: begin
        if (b != wfr_pkg::OP_BINARY && b != wfr_pkg::OP_CLOSE && b != wfr_pkg::OP_CONT) begin
          rx_phase = wfr_pkg::PH_STOP;
          queue_event(wfr_pkg::EV_ERROR, 8'h00, 1'b0);
        end else begin
          frame_op = b;
          rx_phase = wfr_pkg::PH_HDR1;
        end
      end
      wfr_pkg::PH_HDR1: begin
        frame_masked = b[7];
        frame_len_code = b[6:0];
        hdr_count = 3'd0;
        frame_key = 32'd0;
        if (frame_len_code == wfr_pkg::LEN_EXT16 || frame_len_code == wfr_pkg::LEN_EXT64) begin
          payload_left = 64'd0;
          rx_phase = wfr_pkg::PH_EXT;
        end else begin
          payload_left = {57'd0, frame_len_code};
          finish_length();
        end
      end
      wfr_pkg::PH_EXT: begin
        payload_left = {payload_left[55:0], b};
        if (hdr_count >= ((frame_len_code == wfr_pkg::LEN_EXT16) ? 3'd1 : 3'd7))
          finish_length();
        else hdr_count = hdr_count + 3'd1;
      end
      wfr_pkg::PH_MASK: begin
        frame_key = {frame_key[23:0], b};
        if (hdr_count >= 3'd3) finish_header();
        else hdr_count = hdr_count + 3'd1;
      end
      wfr_pkg::PH_DATA: begin
        k = frame_masked ? frame_key[8*(3-key_pos) +: 8] : 8'h00;
        key_pos = key_pos + 2'd1;
        payload_left = payload_left - 64'd1;
        done = (payload_left == 64'd0);
        if (frame_op == wfr_pkg::OP_CLOSE) begin
          if (done) begin
            rx_phase = wfr_pkg::PH_CLOSED;
            queue_event(wfr_pkg::EV_CLOSED, 8'h00, 1'b0);
          end
        end else begin
          if (done) rx_phase = wfr_pkg::PH_HDR0;
          queue_event(wfr_pkg::EV_DATA, b ^ k, done);
        end
      end
      default: ;  // closed or stopped: byte dropped
    endcase
  endtask

  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    rx_byte = b;
    do @(posedge clk); while (!in_ready);
    deframe_byte(b);
    bytes_sent++;
  endtask

  task automatic send_header(input logic [7:0] op, input len_form_t form,
                             input logic [63:0] len, input logic masked,
                             input logic [31:0] key);
    send_byte(op);
    case (form)
      FORM_SHORT: send_byte({masked, len[6:0]});
      FORM_16: begin
        send_byte({masked, wfr_pkg::LEN_EXT16});
        send_byte(len[15:8]);
        send_byte(len[7:0]);
      end
      default: begin
        send_byte({masked, wfr_pkg::LEN_EXT64});
        for (int i = 7; i >= 0; i--) send_byte(len[8*i +: 8]);
      end
    endcase
    if (masked) for (int i = 3; i >= 0; i--) send_byte(key[8*i +: 8]);
  endtask

  task automatic send_payload(input int n);
    repeat (n) send_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic send_frame(input logic [7:0] op, input len_form_t form,
                            input int len, input logic masked, input logic [31:0] key);
    send_header(op, form, 64'(len), masked, key);
    send_payload(len);
  endtask

  task automatic test_directed_frames();
    // extreme payload values through an unmasked frame
    send_header(wfr_pkg::OP_BINARY, FORM_SHORT, 64'd2, 1'b0, 32'd0);
    send_byte(8'h00);
    send_byte(8'hff);
    // key position wraps past the fourth byte
    send_frame(wfr_pkg::OP_CONT, FORM_SHORT, 5, 1'b1, 32'hffff_ffff);
    // empty masked frame: key bytes still consumed, nothing out
    send_frame(wfr_pkg::OP_BINARY, FORM_16, 0, 1'b1, $urandom());
    send_frame(wfr_pkg::OP_CONT, FORM_64, 1, 1'b0, 32'd0);
  endtask

  task automatic test_random_frames(input int budget);
    int        stop_at;
    int        len;
    len_form_t form;
    logic [7:0] op;
    stop_at = bytes_sent + budget;
    while (bytes_sent < stop_at) begin
      op = $urandom_range(0, 1) ? wfr_pkg::OP_BINARY : wfr_pkg::OP_CONT;
      case ($urandom_range(0, 19))
        0, 1: begin
          form = FORM_16;
          len = ($urandom_range(0, 7) == 0) ? $urandom_range(250, 300) : $urandom_range(0, 40);
        end
        2, 3: begin
          form = FORM_64;
          len = $urandom_range(0, 12);
        end
        4: begin
          form = FORM_SHORT;
          len = $urandom_range(100, 125);
        end
        default: begin
          form = FORM_SHORT;
          len = $urandom_range(0, 12);
        end
      endcase
      send_frame(op, form, len, 1'($urandom_range(0, 1)), $urandom());
    end
  endtask

  task automatic test_backpressure();
    // receiver stalls long enough for the block to fill and drop in_ready
    hold_left = 80;
    send_frame(wfr_pkg::OP_BINARY, FORM_SHORT, 60, 1'b1, $urandom());
  endtask

  task automatic test_connection_end();
    conn_end_t  how;
    logic [7:0] bad;
    logic [63:0] huge;
    how = conn_end_t'($urandom_range(0, 2));
    case (how)
      END_ERROR: begin
        do bad = 8'($urandom_range(0, 255));
        while (bad == wfr_pkg::OP_BINARY || bad == wfr_pkg::OP_CLOSE ||
               bad == wfr_pkg::OP_CONT);
        send_byte(bad);
      end
      END_CLOSE:
        send_frame(wfr_pkg::OP_CLOSE, FORM_SHORT, $urandom_range(0, 6),
                   1'($urandom_range(0, 1)), $urandom());
      default: begin
        // top length bit set: the frame never ends within the run
        huge = {$urandom(), $urandom()};
        huge[63] = 1'b1;
        send_header(wfr_pkg::OP_BINARY, FORM_64, huge, 1'($urandom_range(0, 1)),
                    $urandom());
      end
    endcase
    // trailing bytes: dropped after error or close, payload otherwise
    send_payload(12);
  endtask

  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_ready = 1'b0;
      hold_left--;
    end else begin
      out_ready = ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    rx_event_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_events.size() == 0) begin
        $display("%0t: unexpected event kind=%0d byte=%02h end=%0b",
                 $time, event_kind, payload_byte, frame_end);
        errors++;
      end else begin
        want = pending_events.pop_front();
        if (event_kind !== want.kind) begin
          $display("%0t: event_kind expected %0d got %0d", $time, want.kind, event_kind);
          errors++;
        end
        if (payload_byte !== want.data) begin
          $display("%0t: payload_byte expected %02h got %02h", $time, want.data,
                   payload_byte);
          errors++;
        end
        if (frame_end !== want.last) begin
          $display("%0t: frame_end expected %0b got %0b", $time, want.last, frame_end);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("FAIL websocket_frame_receiver");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    rx_byte = 8'h00;
    rx_phase = wfr_pkg::PH_HDR0;
    frame_op = 8'h00;
    frame_masked = 1'b0;
    frame_len_code = 7'd0;
    hdr_count = 3'd0;
    frame_key = 32'd0;
    payload_left = 64'd0;
    key_pos = 2'd0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_idle_pct = 8;
    recv_idle_pct = 54;
    test_directed_frames();
    test_random_frames(170);

    send_idle_pct = 54;
    recv_idle_pct = 8;
    test_random_frames(150);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_backpressure();
    test_random_frames(100);
    test_connection_end();

    @(negedge clk);
    in_valid = 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (errors == 0) $display("PASS websocket_frame_receiver");
    else $display("FAIL websocket_frame_receiver");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/wfr_pkg.sv
hdl/wfr_parser.sv
hdl/websocket_frame_receiver.sv
hdl/wfr_checker.sv
tb/sv/tb_top.sv
